// ===== sv/ffprc_pkg.sv =====
package ffprc_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS  = 16;
  localparam int FRAME_BITS = 16;
  localparam int CAP_W      = 16;
  localparam int BASE_W     = 18;
  localparam int SPEED_W    = 20;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 16;
  localparam int RATE_W     = 19;
  localparam int INTEG_W    = 32;
  localparam int RESID_W    = 24;

  // Configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths, sized to the largest value each register can hold
  localparam int ERR_W      = FRAC_BITS + 1;           // |error| <= 1.0
  localparam int TERM_W     = LIMIT_W + 1;             // signed clamped p or i term
  localparam int RATE_MAG_W = RATE_W - 1;
  localparam int K_W        = 22;                      // rounded base * speed
  localparam int STEP_W     = 24;                      // |rounded k * rate|
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 24;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int RND_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W      = 42;                      // residual + step * frames
  localparam int COUNT_W    = SUM_W - FRAC_BITS;
  localparam int QINT_W     = 23;                      // |error * frames / 1000|

  // Shared divider
  localparam int DVD_W      = 33;
  localparam int DVS_W      = 16;

  // Constants of the control law
  localparam int UNITY      = 1 << FRAC_BITS;
  localparam int HALF       = 1 << (FRAC_BITS - 1);
  localparam int DT_DIVISOR = 1000;                    // integration step of 0.001 per frame

  // Sequencer program counter
  localparam int PC_W       = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 3'd0,
    REG_BASE_RATIO  = 3'd1,
    REG_SPEED       = 3'd2,
    REG_PROP_GAIN   = 3'd3,
    REG_INTEG_GAIN  = 3'd4,
    REG_PROP_LIMIT  = 3'd5,
    REG_INTEG_LIMIT = 3'd6
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [CAP_W-1:0]   capacity;
    logic [BASE_W-1:0]  base_ratio;
    logic [SPEED_W-1:0] speed;
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [LIMIT_W-1:0] prop_limit;
    logic [LIMIT_W-1:0] integ_limit;
  } cfg_t;

  // Datapath operations, one per microcode step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_ERR_NUM,
    OP_ERR_DIV,
    OP_ERR_SET,
    OP_MUL_EF,
    OP_INT_DIV,
    OP_INTEG,
    OP_MUL_P,
    OP_PROP,
    OP_MUL_I,
    OP_INT_TERM,
    OP_RATE,
    OP_MUL_K,
    OP_KRATIO,
    OP_MUL_S,
    OP_STEP,
    OP_MUL_SF,
    OP_SUM,
    OP_COUNT,
    OP_RESID,
    OP_EMIT,
    OP_SKIP
  } op_t;

  // Branch conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ITEM,
    C_SKIP,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  // One microcode word
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic item_in;
    logic skip;
    logic div_busy;
    logic out_busy;
  } stat_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/ffprc_if.sv =====
// Request channel: one frame request or restart per item.
interface ffprc_req_if import ffprc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [FRAME_BITS-1:0] requested_frames;
  logic [FRAME_BITS-1:0] fill_frames;

  modport source(output valid, operation, requested_frames, fill_frames, input ready);
  modport sink(input valid, operation, requested_frames, fill_frames, output ready);
endinterface

// Result channel: frame count and rate factor for each request.
interface ffprc_res_if import ffprc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FRAME_BITS-1:0]    frames_to_read;
  logic signed [RATE_W-1:0] rate_factor;

  modport source(output valid, frames_to_read, rate_factor, input ready);
  modport sink(input valid, frames_to_read, rate_factor, output ready);
endinterface

// ===== sv/ffprc_div.sv =====
// Restoring divider, two quotient bits per cycle. The quotient shifts into
// the dividend register as the dividend bits shift out.
module ffprc_div import ffprc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int PAD_W = DVD_W + (DVD_W % 2);
  localparam int STEPS = PAD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0] num;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DVS_W:0]   r1, r1s, r2, r2s;
  logic             ge1, ge2;

  // Two chained compare-and-subtract stages
  always_comb begin
    r1  = {rem, num[PAD_W-1]};
    ge1 = (r1 >= {1'b0, dvs});
    r1s = ge1 ? (r1 - {1'b0, dvs}) : r1;
    r2  = {r1s[DVS_W-1:0], num[PAD_W-2]};
    ge2 = (r2 >= {1'b0, dvs});
    r2s = ge2 ? (r2 - {1'b0, dvs}) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEPS);
      num  <= PAD_W'(req.dividend);
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      num <= {num[PAD_W-3:0], ge1, ge2};
      rem <= r2s[DVS_W-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = num[DVD_W-1:0];

endmodule

// ===== sv/ffprc_seq.sv =====
// Microcode sequencer: a step counter walks a read-only program. Each word
// names a datapath operation and an optional conditional jump.
module ffprc_seq import ffprc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  // Program step addresses
  localparam logic [PC_W-1:0] S_IDLE     = PC_W'(0);
  localparam logic [PC_W-1:0] S_CHECK    = PC_W'(1);
  localparam logic [PC_W-1:0] S_ERR_NUM  = PC_W'(2);
  localparam logic [PC_W-1:0] S_ERR_DIV  = PC_W'(3);
  localparam logic [PC_W-1:0] S_ERR_WAIT = PC_W'(4);
  localparam logic [PC_W-1:0] S_ERR_SET  = PC_W'(5);
  localparam logic [PC_W-1:0] S_MUL_EF   = PC_W'(6);
  localparam logic [PC_W-1:0] S_INT_DIV  = PC_W'(7);
  localparam logic [PC_W-1:0] S_INT_WAIT = PC_W'(8);
  localparam logic [PC_W-1:0] S_INTEG    = PC_W'(9);
  localparam logic [PC_W-1:0] S_MUL_P    = PC_W'(10);
  localparam logic [PC_W-1:0] S_PROP     = PC_W'(11);
  localparam logic [PC_W-1:0] S_MUL_I    = PC_W'(12);
  localparam logic [PC_W-1:0] S_INT_TERM = PC_W'(13);
  localparam logic [PC_W-1:0] S_RATE     = PC_W'(14);
  localparam logic [PC_W-1:0] S_MUL_K    = PC_W'(15);
  localparam logic [PC_W-1:0] S_KRATIO   = PC_W'(16);
  localparam logic [PC_W-1:0] S_MUL_S    = PC_W'(17);
  localparam logic [PC_W-1:0] S_STEP     = PC_W'(18);
  localparam logic [PC_W-1:0] S_MUL_SF   = PC_W'(19);
  localparam logic [PC_W-1:0] S_SUM      = PC_W'(20);
  localparam logic [PC_W-1:0] S_COUNT    = PC_W'(21);
  localparam logic [PC_W-1:0] S_RESID    = PC_W'(22);
  localparam logic [PC_W-1:0] S_EMIT     = PC_W'(23);
  localparam logic [PC_W-1:0] S_SKIP     = PC_W'(24);

  // Control store
  function automatic ucode_t rom_word(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{OP_NOP, C_NEXT, S_IDLE, 1'b1};
    case (addr)
      S_IDLE:     w = '{OP_LOAD,     C_NO_ITEM,  S_IDLE,     1'b0};
      S_CHECK:    w = '{OP_NOP,      C_SKIP,     S_SKIP,     1'b0};
      S_ERR_NUM:  w = '{OP_ERR_NUM,  C_NEXT,     S_IDLE,     1'b0};
      S_ERR_DIV:  w = '{OP_ERR_DIV,  C_NEXT,     S_IDLE,     1'b0};
      S_ERR_WAIT: w = '{OP_NOP,      C_DIV_BUSY, S_ERR_WAIT, 1'b0};
      S_ERR_SET:  w = '{OP_ERR_SET,  C_NEXT,     S_IDLE,     1'b0};
      S_MUL_EF:   w = '{OP_MUL_EF,   C_NEXT,     S_IDLE,     1'b0};
      S_INT_DIV:  w = '{OP_INT_DIV,  C_NEXT,     S_IDLE,     1'b0};
      S_INT_WAIT: w = '{OP_NOP,      C_DIV_BUSY, S_INT_WAIT, 1'b0};
      S_INTEG:    w = '{OP_INTEG,    C_NEXT,     S_IDLE,     1'b0};
      S_MUL_P:    w = '{OP_MUL_P,    C_NEXT,     S_IDLE,     1'b0};
      S_PROP:     w = '{OP_PROP,     C_NEXT,     S_IDLE,     1'b0};
      S_MUL_I:    w = '{OP_MUL_I,    C_NEXT,     S_IDLE,     1'b0};
      S_INT_TERM: w = '{OP_INT_TERM, C_NEXT,     S_IDLE,     1'b0};
      S_RATE:     w = '{OP_RATE,     C_NEXT,     S_IDLE,     1'b0};
      S_MUL_K:    w = '{OP_MUL_K,    C_NEXT,     S_IDLE,     1'b0};
      S_KRATIO:   w = '{OP_KRATIO,   C_NEXT,     S_IDLE,     1'b0};
      S_MUL_S:    w = '{OP_MUL_S,    C_NEXT,     S_IDLE,     1'b0};
      S_STEP:     w = '{OP_STEP,     C_NEXT,     S_IDLE,     1'b0};
      S_MUL_SF:   w = '{OP_MUL_SF,   C_NEXT,     S_IDLE,     1'b0};
      S_SUM:      w = '{OP_SUM,      C_NEXT,     S_IDLE,     1'b0};
      S_COUNT:    w = '{OP_COUNT,    C_NEXT,     S_IDLE,     1'b0};
      S_RESID:    w = '{OP_RESID,    C_NEXT,     S_IDLE,     1'b0};
      S_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY, S_EMIT,     1'b1};
      S_SKIP:     w = '{OP_SKIP,     C_ALWAYS,   S_EMIT,     1'b0};
      default:    w = '{OP_NOP,      C_NEXT,     S_IDLE,     1'b1};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;
  logic            jump;

  assign word    = rom_word(pc);
  assign ctrl.op = word.op;

  // Branch condition select
  always_comb begin
    case (word.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_ITEM:  jump = !stat.item_in;
      C_SKIP:     jump = stat.skip;
      C_DIV_BUSY: jump = stat.div_busy;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b0;
    endcase
  end

  // Next step: jump target, wrap to the idle step, or fall through
  always_comb begin
    if (jump) begin
      pc_next = word.target;
    end else if (word.fin) begin
      pc_next = S_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== sv/ffprc_dp.sv =====
// Datapath: operand registers, one shared 32x24 multiplier with rounding,
// the controller state and the result register. The sequencer picks the
// operation for each cycle.
module ffprc_dp import ffprc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_t            ctrl,
  input  cfg_t             cfg,
  input  div_rsp_t         div_rsp,
  output div_req_t         div_req,
  output stat_t            stat,
  ffprc_req_if.sink        req,
  ffprc_res_if.source      res
);

  localparam int ISUM_W = INTEG_W + 1;

  // Latched request
  logic                  op_reg;
  logic [FRAME_BITS-1:0] frames;
  logic [FRAME_BITS-1:0] fill;

  // Working registers
  logic [CAP_W-1:0]          num_mag;
  logic                      num_neg;
  logic [ERR_W-1:0]          err_mag;
  logic                      err_neg;
  logic [PROD_W-1:0]         prod;
  logic                      prod_neg;
  logic [INTEG_W-1:0]        integ_mag;
  logic signed [TERM_W-1:0]  p_term;
  logic signed [TERM_W-1:0]  i_term;
  logic signed [RATE_W-1:0]  rate;
  logic [RATE_MAG_W-1:0]     rate_mag;
  logic                      rate_neg;
  logic [K_W-1:0]            k;
  logic [STEP_W-1:0]         s_mag;
  logic signed [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0]        count;

  // Controller state
  logic signed [INTEG_W-1:0] error_integral;
  logic signed [RESID_W-1:0] frame_residual;

  // Result register
  logic                      out_valid;
  logic [FRAME_BITS-1:0]     out_frames;
  logic signed [RATE_W-1:0]  out_rate;
  logic                      out_busy;

  assign out_busy           = out_valid && !res.ready;
  assign req.ready          = (ctrl.op == OP_LOAD);
  assign res.valid          = out_valid;
  assign res.frames_to_read = out_frames;
  assign res.rate_factor    = out_rate;

  assign stat.item_in  = req.valid;
  assign stat.skip     = op_reg || (frames == '0);
  assign stat.div_busy = div_rsp.busy;
  assign stat.out_busy = out_busy;

  // Fill clamp and |capacity - 2*fill|
  logic [CAP_W-1:0] fill_c;
  logic [CAP_W:0]   two_fill;
  logic [CAP_W:0]   cap_x;
  logic             num_neg_c;
  logic [CAP_W:0]   num_mag_c;
  logic [DVS_W-1:0] err_dvs;

  always_comb begin
    fill_c    = (fill > cfg.capacity) ? cfg.capacity : fill;
    two_fill  = {fill_c, 1'b0};
    cap_x     = {1'b0, cfg.capacity};
    num_neg_c = (two_fill > cap_x);
    num_mag_c = num_neg_c ? (two_fill - cap_x) : (cap_x - two_fill);
    err_dvs   = (cfg.capacity == '0) ? DVS_W'(1) : DVS_W'(cfg.capacity);
  end

  // Divider requests, rounding half added to the magnitude
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = err_dvs;
    case (ctrl.op)
      OP_ERR_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'({num_mag, {FRAC_BITS{1'b0}}}) + DVD_W'(err_dvs >> 1);
        div_req.divisor  = err_dvs;
      end
      OP_INT_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(prod[MUL_A_W-1:0]) + DVD_W'(DT_DIVISOR / 2);
        div_req.divisor  = DVS_W'(DT_DIVISOR);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Multiplier operand select, on magnitudes with a separate sign
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_neg;

  always_comb begin
    mul_en  = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (ctrl.op)
      OP_MUL_EF: begin
        mul_a   = MUL_A_W'(err_mag);
        mul_b   = MUL_B_W'(frames);
        mul_neg = err_neg;
      end
      OP_MUL_P: begin
        mul_a   = MUL_A_W'(err_mag);
        mul_b   = MUL_B_W'(cfg.prop_gain);
        mul_neg = err_neg;
      end
      OP_MUL_I: begin
        mul_a   = integ_mag;
        mul_b   = MUL_B_W'(cfg.integ_gain);
        mul_neg = error_integral[INTEG_W-1];
      end
      OP_MUL_K: begin
        mul_a   = MUL_A_W'(cfg.speed);
        mul_b   = MUL_B_W'(cfg.base_ratio);
        mul_neg = 1'b0;
      end
      OP_MUL_S: begin
        mul_a   = MUL_A_W'(k);
        mul_b   = MUL_B_W'(rate_mag);
        mul_neg = rate_neg;
      end
      OP_MUL_SF: begin
        mul_a   = MUL_A_W'(s_mag);
        mul_b   = MUL_B_W'(frames);
        mul_neg = rate_neg;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_neg <= mul_neg;
    end
  end

  // Round-to-nearest of the registered product
  logic [PROD_W-1:0] rnd_sum;
  logic [RND_W-1:0]  rnd;

  assign rnd_sum = prod + PROD_W'(HALF);
  assign rnd     = rnd_sum[PROD_W-1:FRAC_BITS];

  // Integral update with saturation
  logic [QINT_W-1:0]         q_int;
  logic signed [ISUM_W-1:0]  integ_delta;
  logic signed [ISUM_W-1:0]  integ_sum;
  logic signed [INTEG_W-1:0] integ_new;

  always_comb begin
    q_int       = div_rsp.quotient[QINT_W-1:0];
    integ_delta = prod_neg ? -$signed(ISUM_W'(q_int)) : $signed(ISUM_W'(q_int));
    integ_sum   = ISUM_W'(error_integral) + integ_delta;
    if (integ_sum[ISUM_W-1] != integ_sum[INTEG_W-1]) begin
      integ_new = integ_sum[ISUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end
  end

  // Clamped proportional and integral magnitudes
  logic [LIMIT_W-1:0] p_clamp;
  logic [LIMIT_W-1:0] i_clamp;

  assign p_clamp = (rnd > RND_W'(cfg.prop_limit)) ? cfg.prop_limit : rnd[LIMIT_W-1:0];
  assign i_clamp = (rnd > RND_W'(cfg.integ_limit)) ? cfg.integ_limit : rnd[LIMIT_W-1:0];

  // Rate = 1 - p - i
  logic signed [RATE_W-1:0] rate_next;

  assign rate_next = $signed(RATE_W'(UNITY)) - RATE_W'(p_term) - RATE_W'(i_term);

  // Residual accumulation, rounding and saturation
  logic signed [SUM_W-1:0] sf_term;
  logic [SUM_W-1:0]        cnt_sum;
  logic signed [SUM_W-1:0] resid_diff;
  logic                    resid_fits;
  logic signed [RESID_W-1:0] resid_sat;

  always_comb begin
    sf_term    = prod_neg ? -$signed(SUM_W'(prod[SUM_W-3:0]))
                          : $signed(SUM_W'(prod[SUM_W-3:0]));
    cnt_sum    = sum + SUM_W'(HALF);
    resid_diff = sum - $signed(SUM_W'({count, {FRAC_BITS{1'b0}}}));
    resid_fits = (&resid_diff[SUM_W-1:RESID_W-1]) || !(|resid_diff[SUM_W-1:RESID_W-1]);
    if (resid_fits) begin
      resid_sat = resid_diff[RESID_W-1:0];
    end else begin
      resid_sat = resid_diff[SUM_W-1] ? {1'b1, {(RESID_W-1){1'b0}}}
                                      : {1'b0, {(RESID_W-1){1'b1}}};
    end
  end

  // Operation execution
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      error_integral <= '0;
      frame_residual <= '0;
    end else begin
      // An emit in the same cycle reloads the result register instead.
      if (out_valid && res.ready && (ctrl.op != OP_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_LOAD: begin
          if (req.valid) begin
            op_reg <= req.operation;
            frames <= req.requested_frames;
            fill   <= req.fill_frames;
          end
        end
        OP_ERR_NUM: begin
          num_mag <= num_mag_c[CAP_W-1:0];
          num_neg <= num_neg_c;
        end
        OP_ERR_SET: begin
          err_mag <= div_rsp.quotient[ERR_W-1:0];
          err_neg <= num_neg;
        end
        OP_INTEG: begin
          error_integral <= integ_new;
        end
        OP_MUL_P: begin
          // The integral magnitude is formed while the multiplier works on p.
          integ_mag <= error_integral[INTEG_W-1] ? INTEG_W'(-error_integral)
                                                 : INTEG_W'(error_integral);
        end
        OP_PROP: begin
          p_term <= prod_neg ? -$signed(TERM_W'(p_clamp)) : $signed(TERM_W'(p_clamp));
        end
        OP_INT_TERM: begin
          i_term <= prod_neg ? -$signed(TERM_W'(i_clamp)) : $signed(TERM_W'(i_clamp));
        end
        OP_RATE: begin
          rate     <= rate_next;
          rate_neg <= rate_next[RATE_W-1];
          rate_mag <= rate_next[RATE_W-1] ? RATE_MAG_W'(-rate_next) : RATE_MAG_W'(rate_next);
        end
        OP_KRATIO: begin
          k <= rnd[K_W-1:0];
        end
        OP_STEP: begin
          s_mag <= rnd[STEP_W-1:0];
        end
        OP_SUM: begin
          sum <= SUM_W'(frame_residual) + sf_term;
        end
        OP_COUNT: begin
          count <= sum[SUM_W-1] ? '0 : cnt_sum[SUM_W-1:FRAC_BITS];
        end
        OP_RESID: begin
          frame_residual <= resid_sat;
        end
        OP_SKIP: begin
          // Restart clears the controller state; an empty request leaves it.
          if (op_reg) begin
            error_integral <= '0;
            frame_residual <= '0;
          end
          count <= '0;
          rate  <= $signed(RATE_W'(UNITY));
        end
        OP_EMIT: begin
          if (!out_busy) begin
            out_valid  <= 1'b1;
            out_frames <= (count > COUNT_W'(cfg.capacity)) ? FRAME_BITS'(cfg.capacity)
                                                           : count[FRAME_BITS-1:0];
            out_rate   <= rate;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/fifo_fill_pi_rate_control_core.sv =====
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    operation, requested_frames, fill_frames
// res       out  valid/ready    frames_to_read, rate_factor
// cfg       in   cfg_wr_en      cfg_index, cfg_wr_data (no read-back)
//
// A frame request is accepted at the idle step and runs the whole microcode
// program, with two passes through the shared two-bit-per-cycle divider; a
// restart or zero frames jumps from the check step to the skip and emit steps.
// Reset is synchronous and clears the integral, the residual and the result.
// A result waiting on res holds the sequencer at its emit step; req is ready
// only at the idle step.
module fifo_fill_pi_rate_control_core import ffprc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  ffprc_req_if.sink             req,
  ffprc_res_if.source           res
);

  cfg_t     cfg;
  ctrl_t    ctrl;
  stat_t    stat;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity    <= CAP_W'(4096);
      cfg.base_ratio  <= BASE_W'(UNITY);
      cfg.speed       <= SPEED_W'(UNITY);
      cfg.prop_gain   <= '0;
      cfg.integ_gain  <= '0;
      cfg.prop_limit  <= '0;
      cfg.integ_limit <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CAPACITY:    cfg.capacity    <= cfg_wr_data[CAP_W-1:0];
        REG_BASE_RATIO:  cfg.base_ratio  <= cfg_wr_data[BASE_W-1:0];
        REG_SPEED:       cfg.speed       <= cfg_wr_data[SPEED_W-1:0];
        REG_PROP_GAIN:   cfg.prop_gain   <= cfg_wr_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg.integ_gain  <= cfg_wr_data[GAIN_W-1:0];
        REG_PROP_LIMIT:  cfg.prop_limit  <= cfg_wr_data[LIMIT_W-1:0];
        REG_INTEG_LIMIT: cfg.integ_limit <= cfg_wr_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ffprc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ffprc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ffprc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .cfg     (cfg),
    .div_rsp (div_rsp),
    .div_req (div_req),
    .stat    (stat),
    .req     (req),
    .res     (res)
  );

endmodule
